// ===== rtl/dmc_pkg.sv =====
// dmc_pkg: constants, word types and helper functions of the depth-first maze carver
// used by dfs_maze_carver and dmc_walker, depends on nothing
package dmc_pkg;

  localparam int MAX_SIDE = 64;
  localparam int COORD_W  = $clog2(MAX_SIDE);
  localparam int CELLS    = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int SIZE_W   = 7;
  localparam int WALL_W   = 13;
  localparam int RAND_W   = 8;

  localparam logic [SIZE_W-1:0] SIDE_MIN   = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] SIDE_MAX   = SIZE_W'(MAX_SIDE);
  localparam logic [SIZE_W-1:0] SIDE_RESET = SIZE_W'(40);

  localparam logic ACT_CARVE   = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  localparam logic [1:0] KIND_CARVED    = 2'd0;
  localparam logic [1:0] KIND_BACKTRACK = 2'd1;
  localparam logic [1:0] KIND_RESTART   = 2'd2;
  localparam logic [1:0] KIND_IDLE      = 2'd3;

  localparam logic [1:0] DIR_TOP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT  = 2'd1;
  localparam logic [1:0] DIR_BOTTOM = 2'd2;
  localparam logic [1:0] DIR_LEFT   = 2'd3;

  typedef struct packed {
    logic              action;
    logic [RAND_W-1:0] rand_byte;
  } in_word_t;

  typedef struct packed {
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [1:0]         step_kind;
    logic [1:0]         direction;
    logic [WALL_W-1:0]  removed_wall;
    logic               finished;
  } out_word_t;

  function automatic logic [SIZE_W-1:0] clamp_side(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s < SIDE_MIN) r = SIDE_MIN;
    if (s > SIDE_MAX) r = SIDE_MAX;
    return r;
  endfunction

  // rand mod count for count 1..4
  function automatic logic [1:0] pick_index(input logic [RAND_W-1:0] rnd,
                                            input logic [2:0] cnt);
    logic [1:0] r;
    logic [3:0] s4;
    logic [2:0] s2;
    // base-4 digit sums keep the residue mod 3
    s4 = 4'(rnd[1:0]) + 4'(rnd[3:2]) + 4'(rnd[5:4]) + 4'(rnd[7:6]);
    s2 = 3'(s4[1:0]) + 3'(s4[3:2]);
    unique case (cnt)
      3'd2:    r = {1'b0, rnd[0]};
      3'd3: begin
        priority if (s2 >= 3'd6) begin
          r = 2'd0;
        end else if (s2 >= 3'd3) begin
          r = 2'(s2 - 3'd3);
        end else begin
          r = s2[1:0];
        end
      end
      3'd4:    r = rnd[1:0];
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // position of the n-th set bit, counted from bit 0
  function automatic logic [1:0] nth_set(input logic [3:0] c, input logic [1:0] n);
    logic [1:0] seen;
    logic [1:0] sel;
    seen = 2'd0;
    sel  = 2'd0;
    for (int k = 0; k < 4; k++) begin
      if (c[k]) begin
        if (seen == n) sel = 2'(k);
        seen = seen + 2'd1;
      end
    end
    return sel;
  endfunction

endpackage

// ===== rtl/dfs_maze_carver.sv =====
// dfs_maze_carver: top level, grid size register, output register and the step sequencer
// depends on dmc_pkg and dmc_walker
//
//   channel  ports                                  word
//   in       in_valid, in_stall, in_word            action, rand_byte
//   out      out_valid, out_stall, out_word         cell, kind, direction, wall, finished
//   cfg      cfg_wr_en, cfg_wr_data                 grid_size
//
// one item at a time: a carve step keeps the walker busy for the accept, three further
// visited-map reads and the pick, a backtrack also for a stack read after the pick;
// restart and idle answers are made at the accept; the answer then goes to the output
// register before the next word is taken
// after reset, a restart word and a grid_size write, a clearing pass sweeps every entry of
// the visited map; no word is accepted during it
// the result waits in a holding register and then the output register, so a stalled
// output still lets the next word in
module dfs_maze_carver
  import dmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_word,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data
);

  logic [SIZE_W-1:0] side_r, side_nxt;
  logic [CNT_W-1:0]  side_sq_r, side_sq_nxt;
  logic              out_valid_r;
  out_word_t         out_word_r;
  logic              res_valid, res_take;
  out_word_t         res_word;

  assign side_nxt    = clamp_side(cfg_wr_data);
  assign side_sq_nxt = CNT_W'(side_nxt) * CNT_W'(side_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r    <= SIDE_RESET;
      side_sq_r <= CNT_W'(SIDE_RESET) * CNT_W'(SIDE_RESET);
    end else if (cfg_wr_en) begin
      side_r    <= side_nxt;
      side_sq_r <= side_sq_nxt;
    end
  end

  dmc_walker u_walker (
    .clk         (clk),
    .rst_n       (rst_n),
    .side        (side_r),
    .side_sq     (side_sq_r),
    .restart_cfg (cfg_wr_en),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .res_valid   (res_valid),
    .res_word    (res_word),
    .res_take    (res_take)
  );

  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== rtl/dmc_ram.sv =====
// dmc_ram: generic single-clock ram, one write and one read port, registered read data
// no dependencies
module dmc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/dmc_walker.sv =====
// dmc_walker: step sequencer of the carver, holds the visited map and the path stack
// depends on dmc_pkg and dmc_ram
module dmc_walker
  import dmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SIZE_W-1:0] side,
  input  logic [CNT_W-1:0]  side_sq,
  input  logic              restart_cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_word,
  output logic              res_valid,
  output out_word_t         res_word,
  input  logic              res_take
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_PICK  = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [COORD_W-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [CNT_W-1:0]   depth_r, depth_nxt, vcount_r, vcount_nxt;
  logic               done_r, done_nxt;
  logic [RAND_W-1:0]  rand_r, rand_nxt;
  logic [1:0]         rd_cnt_r, rd_cnt_nxt;
  logic [2:0]         nb_vis_r, nb_vis_nxt;
  logic [WALL_W-1:0]  prod_r, prod_nxt;
  out_word_t          res_r, res_nxt;
  logic               res_valid_r, res_valid_nxt;

  logic               vis_we, vis_wdata, vis_rdata;
  logic [ADDR_W-1:0]  vis_waddr, vis_raddr;
  logic               stk_we;
  logic [ADDR_W-1:0]  stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  logic               accept;
  logic [3:0]         inb, vis4, cand;
  logic [2:0]         cand_cnt;
  logic [1:0]         dir;
  logic [COORD_W-1:0] nx, ny;
  logic [WALL_W-1:0]  owner;
  logic               wall_bit;
  logic [CNT_W-1:0]   vcount_inc;

  function automatic logic [ADDR_W-1:0] nb_addr(input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y,
                                                input logic [1:0] k);
    logic [ADDR_W-1:0] a;
    unique case (k)
      DIR_TOP:    a = {y - COORD_W'(1), x};
      DIR_RIGHT:  a = {y, x + COORD_W'(1)};
      DIR_BOTTOM: a = {y + COORD_W'(1), x};
      default:    a = {y, x - COORD_W'(1)};
    endcase
    return a;
  endfunction

  dmc_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (vis_raddr),
    .rdata (vis_rdata)
  );

  dmc_ram #(.WIDTH(ADDR_W), .DEPTH(CELLS)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign in_stall  = !((state_r == S_IDLE) && !res_valid_r);
  assign accept    = in_valid && !in_stall;
  assign res_valid = res_valid_r;
  assign res_word  = res_r;

  assign inb[0] = (cur_y_r != '0);
  assign inb[1] = (({1'b0, cur_x_r} + SIZE_W'(1)) < side);
  assign inb[2] = (({1'b0, cur_y_r} + SIZE_W'(1)) < side);
  assign inb[3] = (cur_x_r != '0);
  assign vis4     = {vis_rdata, nb_vis_r};
  assign cand     = inb & ~vis4;
  assign cand_cnt = 3'($countones(cand));
  assign dir      = nth_set(cand, pick_index(rand_r, cand_cnt));
  assign vcount_inc = vcount_r + CNT_W'(1);

  always_comb begin
    nx       = cur_x_r;
    ny       = cur_y_r;
    owner    = prod_r + WALL_W'(cur_x_r);
    wall_bit = 1'b0;
    unique case (dir)
      DIR_TOP: begin
        ny       = cur_y_r - COORD_W'(1);
        wall_bit = 1'b1;
      end
      DIR_RIGHT: begin
        nx    = cur_x_r + COORD_W'(1);
        owner = prod_r + WALL_W'(cur_x_r) + WALL_W'(1);
      end
      DIR_BOTTOM: begin
        ny       = cur_y_r + COORD_W'(1);
        owner    = prod_r + WALL_W'(side) + WALL_W'(cur_x_r);
        wall_bit = 1'b1;
      end
      default: begin
        nx = cur_x_r - COORD_W'(1);
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    depth_nxt     = depth_r;
    vcount_nxt    = vcount_r;
    done_nxt      = done_r;
    rand_nxt      = rand_r;
    rd_cnt_nxt    = rd_cnt_r;
    nb_vis_nxt    = nb_vis_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !res_take;

    vis_we    = 1'b0;
    vis_waddr = clr_addr_r;
    vis_wdata = 1'b0;
    vis_raddr = nb_addr(cur_x_r, cur_y_r, rd_cnt_r);
    stk_we    = 1'b0;
    stk_waddr = depth_r[ADDR_W-1:0];
    stk_wdata = {ny, nx};
    stk_raddr = ADDR_W'(depth_r - CNT_W'(2));

    if (restart_cfg) begin
      state_nxt    = S_CLEAR;
      clr_addr_nxt = '0;
      cur_x_nxt    = '0;
      cur_y_nxt    = '0;
      depth_nxt    = CNT_W'(1);
      vcount_nxt   = CNT_W'(1);
      done_nxt     = 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          vis_we       = 1'b1;
          vis_waddr    = clr_addr_r;
          vis_wdata    = (clr_addr_r == '0);
          clr_addr_nxt = clr_addr_r + ADDR_W'(1);
          if (clr_addr_r == '1) state_nxt = S_IDLE;
        end
        S_IDLE: begin
          vis_raddr = nb_addr(cur_x_r, cur_y_r, DIR_TOP);
          if (accept) begin
            rand_nxt = in_word.rand_byte;
            priority if (in_word.action == ACT_RESTART) begin
              state_nxt     = S_CLEAR;
              clr_addr_nxt  = '0;
              cur_x_nxt     = '0;
              cur_y_nxt     = '0;
              depth_nxt     = CNT_W'(1);
              vcount_nxt    = CNT_W'(1);
              done_nxt      = 1'b0;
              res_nxt       = '{cell_x: '0, cell_y: '0, step_kind: KIND_RESTART,
                                direction: '0, removed_wall: '0, finished: 1'b0};
              res_valid_nxt = 1'b1;
            end else if (done_r) begin
              res_nxt       = '{cell_x: cur_x_r, cell_y: cur_y_r, step_kind: KIND_IDLE,
                                direction: '0, removed_wall: '0, finished: 1'b1};
              res_valid_nxt = 1'b1;
            end else begin
              state_nxt  = S_READ;
              rd_cnt_nxt = 2'd1;
              prod_nxt   = WALL_W'(cur_y_r) * WALL_W'(side);
            end
          end
        end
        S_READ: begin
          vis_raddr  = nb_addr(cur_x_r, cur_y_r, rd_cnt_r);
          nb_vis_nxt[rd_cnt_r - 2'd1] = vis_rdata;
          rd_cnt_nxt = rd_cnt_r + 2'd1;
          if (rd_cnt_r == 2'd3) state_nxt = S_PICK;
        end
        S_PICK: begin
          priority if ((cand_cnt != 3'd0) && (depth_r != CNT_W'(CELLS))) begin
            vis_we        = 1'b1;
            vis_waddr     = {ny, nx};
            vis_wdata     = 1'b1;
            stk_we        = 1'b1;
            depth_nxt     = depth_r + CNT_W'(1);
            vcount_nxt    = vcount_inc;
            done_nxt      = done_r || (vcount_inc >= side_sq);
            cur_x_nxt     = nx;
            cur_y_nxt     = ny;
            res_nxt       = '{cell_x: nx, cell_y: ny, step_kind: KIND_CARVED,
                              direction: dir, removed_wall: {owner[WALL_W-2:0], wall_bit},
                              finished: done_r || (vcount_inc >= side_sq)};
            res_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else if (depth_r > CNT_W'(1)) begin
            state_nxt = S_POP;
          end else begin
            res_nxt       = '{cell_x: cur_x_r, cell_y: cur_y_r, step_kind: KIND_BACKTRACK,
                              direction: '0, removed_wall: '0, finished: done_r};
            res_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
        S_POP: begin
          // start cell sits below every pushed entry
          if (depth_r == CNT_W'(2)) begin
            cur_x_nxt = '0;
            cur_y_nxt = '0;
          end else begin
            cur_x_nxt = stk_rdata[COORD_W-1:0];
            cur_y_nxt = stk_rdata[ADDR_W-1:COORD_W];
          end
          depth_nxt     = depth_r - CNT_W'(1);
          res_nxt       = '{cell_x: cur_x_nxt, cell_y: cur_y_nxt, step_kind: KIND_BACKTRACK,
                            direction: '0, removed_wall: '0, finished: done_r};
          res_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
        default: begin
          state_nxt = S_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      depth_r     <= CNT_W'(1);
      vcount_r    <= CNT_W'(1);
      done_r      <= 1'b0;
      rd_cnt_r    <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      depth_r     <= depth_nxt;
      vcount_r    <= vcount_nxt;
      done_r      <= done_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rand_r   <= rand_nxt;
    nb_vis_r <= nb_vis_nxt;
    prod_r   <= prod_nxt;
    res_r    <= res_nxt;
  end

endmodule
